// ===== rtl/core/hwe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwe_pkg: shared types and constants of the whitespace escaper
// code unit constants, the nbsp entity text and the per-beat plan record
// ----------------------------------------------------------------------------
package hwe_pkg;

	localparam int TAB_SPACES_DEF = 4;
	localparam int TAB_MAX        = 8;
	localparam int RES_MAX        = 48;
	localparam int NBSP_LEN       = 6;

	typedef logic [15:0] unit_t;
	typedef logic [3:0]  ncnt_t;
	typedef logic [2:0]  chidx_t;
	typedef logic [5:0]  rcnt_t;

	localparam unit_t CH_SPACE = 16'h0020;
	localparam unit_t CH_TAB   = 16'h0009;
	localparam unit_t CH_CR    = 16'h000D;
	localparam unit_t CH_LT    = 16'h003C;
	localparam unit_t CH_GT    = 16'h003E;
	localparam unit_t CH_DQUOT = 16'h0022;
	localparam unit_t CH_SQUOT = 16'h0027;
	localparam unit_t CH_NONE  = 16'h0000;

	localparam chidx_t NBSP_LAST = 3'(NBSP_LEN - 1);

	// work left for one accepted beat
	typedef struct packed {
		ncnt_t  a_rem;
		logic   a_space;
		ncnt_t  b_rem;
		logic   b_space;
		logic   has_char;
		unit_t  char_unit;
		chidx_t k;
		rcnt_t  remaining;
		logic   last;
	} plan_t;

	function automatic unit_t nbsp_char(input chidx_t k);
		unit_t u;
		case (k)
			3'd0:    u = 16'h0026;
			3'd1:    u = 16'h006E;
			3'd2:    u = 16'h0062;
			3'd3:    u = 16'h0073;
			3'd4:    u = 16'h0070;
			3'd5:    u = 16'h003B;
			default: u = CH_NONE;
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hwe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwe_if: stream channels of the whitespace escaper
// input channel of code units and output channel of converted units
// ----------------------------------------------------------------------------
interface hwe_in_if;
	logic           valid;
	logic           ready;
	hwe_pkg::unit_t code_unit;
	logic           line_last;
	logic           convert_all;

	modport source (output valid, output code_unit, output line_last,
		output convert_all, input ready);
	modport sink (input valid, input code_unit, input line_last,
		input convert_all, output ready);
endinterface

interface hwe_out_if;
	logic           valid;
	logic           ready;
	hwe_pkg::unit_t out_unit;
	logic           has_unit;
	logic           run_last;
	logic           line_end;

	modport source (output valid, output out_unit, output has_unit,
		output run_last, output line_end, input ready);
	modport sink (input valid, input out_unit, input has_unit,
		input run_last, input line_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/html_whitespace_escaper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// html_whitespace_escaper: nbsp conversion of whitespace outside markup tags
// path: plan held in the sequencer stage, each result in the output register
// throughput: one beat per cycle if dst is ready and beats give <= 1 result;
//   n results of a beat (n <= 48) hold the result sequencer until all are out
// reset: tag tracking, held whitespace and all valid flags clear, line start set
// ----------------------------------------------------------------------------
module html_whitespace_escaper #(
	parameter int TAB_SPACES = hwe_pkg::TAB_SPACES_DEF
) (
	input  wire      clk,
	input  wire      arst_n,
	hwe_in_if.sink   src,
	hwe_out_if.source dst
);
	import hwe_pkg::*;

	localparam int    TabClamped = (TAB_SPACES < 1) ? 1 :
		((TAB_SPACES > TAB_MAX) ? TAB_MAX : TAB_SPACES);
	localparam ncnt_t TabExtra   = ncnt_t'(TabClamped - 1);

	// line state
	logic inside_tag_q, inside_attr_quote_q, quote_is_single_q;
	logic pending_valid_q, pending_is_tab_q, pending_was_first_q;
	logic at_line_start_q;

	// sequencer stage
	logic  valid_s1;
	plan_t plan_s1;

	// output register
	logic  out_valid_q;
	unit_t out_unit_q;
	logic  has_unit_q, run_last_q, line_end_q;

	// accept-side decode
	logic  accept, is_ws, is_tab, ext_a, ext_b;
	logic  t_tag, t_quote, t_single;
	logic  new_pending;
	plan_t plan_in;
	logic [6:0] tot;

	// sequencer
	logic  out_load, advance, finishing, nb_ph, sp_ph;
	unit_t cur_unit;
	plan_t plan_nx;

	always_comb begin
		is_ws  = (src.code_unit == CH_SPACE) || (src.code_unit == CH_TAB);
		is_tab = (src.code_unit == CH_TAB);

		t_tag    = inside_tag_q;
		t_quote  = inside_attr_quote_q;
		t_single = quote_is_single_q;
		if (inside_tag_q) begin
			if (inside_attr_quote_q) begin
				if (src.code_unit == (quote_is_single_q ? CH_SQUOT : CH_DQUOT))
					t_quote = 1'b0;
			end else if (src.code_unit == CH_DQUOT || src.code_unit == CH_SQUOT) begin
				t_quote  = 1'b1;
				t_single = (src.code_unit == CH_SQUOT);
			end else if (src.code_unit == CH_GT) begin
				t_tag = 1'b0;
			end
		end else if (src.code_unit == CH_LT) begin
			t_tag   = 1'b1;
			t_quote = 1'b0;
		end

		plan_in           = '0;
		plan_in.char_unit = src.code_unit;
		plan_in.last      = src.line_last;

		// held whitespace from the previous beat
		ext_a = is_ws || src.convert_all || pending_was_first_q;
		if (pending_valid_q) begin
			plan_in.a_rem   = (pending_is_tab_q ? TabExtra : ncnt_t'(0)) + ncnt_t'(ext_a);
			plan_in.a_space = !ext_a;
		end

		ext_b       = src.convert_all || at_line_start_q;
		new_pending = 1'b0;
		if (t_tag) begin
			plan_in.has_char = 1'b1;
		end else if (is_ws) begin
			if (src.line_last) begin
				plan_in.b_rem   = (is_tab ? TabExtra : ncnt_t'(0)) + ncnt_t'(ext_b);
				plan_in.b_space = !ext_b;
			end else begin
				new_pending = 1'b1;
			end
		end else if (src.code_unit != CH_CR) begin
			plan_in.has_char = 1'b1;
		end

		tot = 7'({plan_in.a_rem, 2'b00}) + 7'({plan_in.a_rem, 1'b0})
			+ 7'({plan_in.b_rem, 2'b00}) + 7'({plan_in.b_rem, 1'b0})
			+ 7'(plan_in.a_space) + 7'(plan_in.b_space) + 7'(plan_in.has_char);
		if (tot == 7'd0 && src.line_last)
			tot = 7'd1;
		if (tot > 7'(RES_MAX))
			tot = 7'(RES_MAX);
		plan_in.remaining = rcnt_t'(tot);
	end

	always_comb begin
		out_load  = !out_valid_q || dst.ready;
		advance   = valid_s1 && out_load;
		finishing = advance && (plan_s1.remaining == rcnt_t'(1));
		src.ready = !valid_s1 || finishing;
		accept    = src.valid && src.ready;

		nb_ph = (plan_s1.a_rem != '0) || (!plan_s1.a_space && plan_s1.b_rem != '0);
		sp_ph = !nb_ph && (plan_s1.a_space || plan_s1.b_space);
		if (nb_ph)
			cur_unit = nbsp_char(plan_s1.k);
		else if (sp_ph)
			cur_unit = CH_SPACE;
		else if (plan_s1.has_char)
			cur_unit = plan_s1.char_unit;
		else
			cur_unit = CH_NONE;

		plan_nx           = plan_s1;
		plan_nx.remaining = plan_s1.remaining - rcnt_t'(1);
		if (nb_ph) begin
			if (plan_s1.k == NBSP_LAST) begin
				plan_nx.k = '0;
				if (plan_s1.a_rem != '0)
					plan_nx.a_rem = plan_s1.a_rem - ncnt_t'(1);
				else
					plan_nx.b_rem = plan_s1.b_rem - ncnt_t'(1);
			end else begin
				plan_nx.k = plan_s1.k + chidx_t'(1);
			end
		end else if (plan_s1.a_space) begin
			plan_nx.a_space = 1'b0;
		end else if (plan_s1.b_space) begin
			plan_nx.b_space = 1'b0;
		end else begin
			plan_nx.has_char = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q        <= 1'b0;
			inside_attr_quote_q <= 1'b0;
			quote_is_single_q   <= 1'b0;
			pending_valid_q     <= 1'b0;
			pending_is_tab_q    <= 1'b0;
			pending_was_first_q <= 1'b0;
			at_line_start_q     <= 1'b1;
		end else if (accept) begin
			if (src.line_last) begin
				inside_tag_q        <= 1'b0;
				inside_attr_quote_q <= 1'b0;
				quote_is_single_q   <= 1'b0;
				pending_valid_q     <= 1'b0;
				pending_is_tab_q    <= 1'b0;
				pending_was_first_q <= 1'b0;
				at_line_start_q     <= 1'b1;
			end else begin
				inside_tag_q        <= t_tag;
				inside_attr_quote_q <= t_quote;
				quote_is_single_q   <= t_single;
				pending_valid_q     <= new_pending;
				if (new_pending) begin
					pending_is_tab_q    <= is_tab;
					pending_was_first_q <= at_line_start_q;
				end
				at_line_start_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (plan_in.remaining != '0);
		end else if (finishing) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			plan_s1 <= plan_in;
		else if (advance)
			plan_s1 <= plan_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_unit_q <= cur_unit;
			has_unit_q <= nb_ph || sp_ph || plan_s1.has_char;
			run_last_q <= (plan_s1.remaining == rcnt_t'(1));
			line_end_q <= (plan_s1.remaining == rcnt_t'(1)) && plan_s1.last;
		end
	end

	assign dst.valid    = out_valid_q;
	assign dst.out_unit = out_unit_q;
	assign dst.has_unit = has_unit_q;
	assign dst.run_last = run_last_q;
	assign dst.line_end = line_end_q;

endmodule
`default_nettype wire
